// ----- hdl/lscp_pkg.sv -----
// Shared constants and control/status types of the light show command processor.
`default_nettype none

package lscp_pkg;

    localparam int BYTE_W   = 8;
    localparam int ID_W     = 24;
    localparam int SHOW_W   = 16;
    localparam int RGB_W    = 24;
    localparam int STATUS_W = 3;
    localparam int PKT_W    = 56;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_PWM_TOP     = 255;

    // Command bytes
    localparam logic [BYTE_W-1:0] CMD_ARM  = 8'h50;
    localparam logic [BYTE_W-1:0] CMD_SHOW = 8'h42;
    localparam logic [BYTE_W-1:0] CMD_SAVE = 8'h53;
    localparam logic [BYTE_W-1:0] CMD_PROG = 8'h49;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DUP   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ARMED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHOWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WROTE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SAVE  = 3'd5;

    typedef struct packed {
        logic capture;     // take the request into the packet register
        logic commit;      // decode the held packet and apply its effects
        logic load_show;   // load playback levels from the table read
        logic clear_step;  // zero one table entry and advance the sweep
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;    // result register can take a new result now
        logic show_read;   // held packet is a fresh playback command
        logic arm_hit;     // held packet is a fresh arm with matching id
        logic clear_done;  // sweep is at its last entry
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/lscp_ram.sv -----
// Generic single write port RAM with registered read.
`default_nettype none

module lscp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/lscp_ctrl.sv -----
// Sequencing state machine: table sweep, request intake, decode and playback read.
`default_nettype none

module lscp_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire lscp_pkg::t_dp_status  i_status,
    output lscp_pkg::t_ctrl_cmd        o_cmd,
    output logic                       o_ready
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && r_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                // hold until the result register has room
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    priority if (i_status.show_read) begin
                        n_state = S_READ;
                    end else if (i_status.arm_hit) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_show = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_ready = r_ready;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");

    a_arm_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit && i_status.arm_hit) |=> (r_state == S_CLEAR))
        else $error("arm did not start table sweep");

    a_read_follows_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit && i_status.show_read) |=> o_cmd.load_show)
        else $error("playback load missing after show decode");
`endif

endmodule

`default_nettype wire

// ----- hdl/lscp_dp.sv -----
// Datapath: packet and duplicate registers, show number, colour table, result register.
`default_nettype none

module lscp_dp #(
    parameter int TABLE_DEPTH = lscp_pkg::DEF_TABLE_DEPTH,
    parameter int PWM_TOP     = lscp_pkg::DEF_PWM_TOP
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lscp_pkg::t_ctrl_cmd               i_cmd,
    output lscp_pkg::t_dp_status                   o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [lscp_pkg::ID_W-1:0]         i_cfg_wdata,
    input  wire logic [lscp_pkg::BYTE_W-1:0]       i_kind,
    input  wire logic [lscp_pkg::BYTE_W-1:0]       i_arg_1,
    input  wire logic [lscp_pkg::BYTE_W-1:0]       i_arg_2,
    input  wire logic [lscp_pkg::BYTE_W-1:0]       i_arg_3,
    input  wire logic [lscp_pkg::BYTE_W-1:0]       i_arg_4,
    input  wire logic [lscp_pkg::BYTE_W-1:0]       i_arg_5,
    input  wire logic [lscp_pkg::BYTE_W-1:0]       i_arg_6,
    input  wire logic                              i_stall,
    output logic                                   o_valid,
    output logic [lscp_pkg::STATUS_W-1:0]          o_status_code,
    output logic                                   o_drive_update,
    output logic [lscp_pkg::BYTE_W-1:0]            o_red_level,
    output logic [lscp_pkg::BYTE_W-1:0]            o_green_level,
    output logic [lscp_pkg::BYTE_W-1:0]            o_blue_level
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [lscp_pkg::BYTE_W:0] DEPTH_LIM = (lscp_pkg::BYTE_W+1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [lscp_pkg::BYTE_W-1:0] TOP = lscp_pkg::BYTE_W'(PWM_TOP);

    function automatic logic [lscp_pkg::BYTE_W-1:0] invert_level(
        input logic [lscp_pkg::BYTE_W-1:0] c
    );
        logic [lscp_pkg::BYTE_W-1:0] lvl;
        if (c > TOP) begin
            lvl = '0;
        end else begin
            lvl = TOP - c;
        end
        return lvl;
    endfunction

    // held request
    logic [lscp_pkg::BYTE_W-1:0] r_kind, r_arg_1, r_arg_2, r_arg_3, r_arg_4, r_arg_5, r_arg_6;
    logic [lscp_pkg::PKT_W-1:0]  r_last;
    logic [lscp_pkg::SHOW_W-1:0] r_show;
    logic [lscp_pkg::ID_W-1:0]   r_pack_id;
    logic [IDX_W-1:0]            r_clr_idx;
    logic                        r_show_oob;

    // result register
    logic                          r_out_valid;
    logic [lscp_pkg::STATUS_W-1:0] r_out_status;
    logic                          r_out_drive;
    logic [lscp_pkg::BYTE_W-1:0]   r_out_red, r_out_green, r_out_blue;

    logic [lscp_pkg::PKT_W-1:0]    pkt;
    logic [lscp_pkg::SHOW_W-1:0]   sn;
    logic                          dup;
    logic                          id_hit;
    logic                          sn_hit;
    logic                          prog_in_range;
    logic                          prog_write;
    logic                          load;
    logic [lscp_pkg::STATUS_W-1:0] n_status;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [lscp_pkg::RGB_W-1:0]  ram_wdata;
    logic [lscp_pkg::RGB_W-1:0]  ram_rdata;
    logic [lscp_pkg::RGB_W-1:0]  colour;

    assign pkt = {r_arg_6, r_arg_5, r_arg_4, r_arg_3, r_arg_2, r_arg_1, r_kind};
    assign sn  = {r_arg_2, r_arg_1};
    assign dup = (pkt == r_last);
    assign id_hit = ({r_arg_3, r_arg_2, r_arg_1} == r_pack_id);
    assign sn_hit = (sn == r_show);
    assign prog_in_range = ({1'b0, r_arg_3} < DEPTH_LIM);

    always_comb begin
        n_status = lscp_pkg::ST_MISS;
        if (dup) begin
            n_status = lscp_pkg::ST_DUP;
        end else begin
            unique case (r_kind)
                lscp_pkg::CMD_ARM:  if (id_hit) n_status = lscp_pkg::ST_ARMED;
                lscp_pkg::CMD_SHOW: n_status = lscp_pkg::ST_SHOWN;
                lscp_pkg::CMD_SAVE: if (sn_hit) n_status = lscp_pkg::ST_SAVE;
                lscp_pkg::CMD_PROG: if (sn_hit && prog_in_range) n_status = lscp_pkg::ST_WROTE;
                default:            n_status = lscp_pkg::ST_MISS;
            endcase
        end
    end

    assign o_status.show_read  = !dup && (r_kind == lscp_pkg::CMD_SHOW);
    assign o_status.arm_hit    = !dup && (r_kind == lscp_pkg::CMD_ARM) && id_hit;
    assign o_status.clear_done = (r_clr_idx == LAST_IDX);
    assign o_status.out_free   = !r_out_valid || !i_stall;

    assign prog_write = i_cmd.commit && (n_status == lscp_pkg::ST_WROTE);
    assign load = (i_cmd.commit && !o_status.show_read) || i_cmd.load_show;

    // sweep writes zeros; otherwise a program command writes its entry
    assign ram_we    = i_cmd.clear_step || prog_write;
    assign ram_waddr = i_cmd.clear_step ? r_clr_idx : r_arg_3[IDX_W-1:0];
    assign ram_wdata = i_cmd.clear_step ? '0 : {r_arg_4, r_arg_5, r_arg_6};

    lscp_ram #(
        .WIDTH (lscp_pkg::RGB_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_arg_1[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // entries beyond the table read as black
    assign colour = r_show_oob ? '0 : ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_show      <= '1;
            r_pack_id   <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pack_id <= i_cfg_wdata;
            end
            if (i_cmd.commit && !dup) begin
                r_last <= pkt;
            end
            if (i_cmd.commit && o_status.arm_hit) begin
                r_show <= {r_arg_5, r_arg_4};
            end
            if (i_cmd.clear_step) begin
                r_clr_idx <= o_status.clear_done ? '0 : r_clr_idx + 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_arg_1 <= i_arg_1;
            r_arg_2 <= i_arg_2;
            r_arg_3 <= i_arg_3;
            r_arg_4 <= i_arg_4;
            r_arg_5 <= i_arg_5;
            r_arg_6 <= i_arg_6;
        end
        if (i_cmd.commit) begin
            r_show_oob <= !({1'b0, r_arg_1} < DEPTH_LIM);
        end
        if (i_cmd.load_show) begin
            r_out_status <= lscp_pkg::ST_SHOWN;
            r_out_drive  <= 1'b1;
            r_out_red    <= invert_level(colour[23:16]);
            r_out_green  <= invert_level(colour[15:8]);
            r_out_blue   <= invert_level(colour[7:0]);
        end else if (load) begin
            r_out_status <= n_status;
            r_out_drive  <= 1'b0;
            r_out_red    <= '0;
            r_out_green  <= '0;
            r_out_blue   <= '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status_code  = r_out_status;
    assign o_drive_update = r_out_drive;
    assign o_red_level    = r_out_red;
    assign o_green_level  = r_out_green;
    assign o_blue_level   = r_out_blue;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !load)
        else $error("result overwritten while stalled");

    a_write_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clear_step && (i_cmd.commit || i_cmd.capture)))
        else $error("table sweep overlaps request handling");

    a_drive_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_drive == (r_out_status == lscp_pkg::ST_SHOWN)))
        else $error("drive update disagrees with status");
`endif

endmodule

`default_nettype wire

// ----- hdl/light_show_command_processor.sv -----
// Top level of the light show command processor: controller plus datapath.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_kind, i_arg_1 .. i_arg_6
//   result    out        o_valid / i_stall   o_status, o_drive_update, o_*_level
//   config    in         i_cfg_we            i_cfg_wdata (pack id)
//
// A request passes through intake and decode; playback adds the registered colour
// table read after decode. An accepted arm adds a sweep that zeroes the table one
// entry per cycle. After reset the same sweep runs before the first request is
// taken. Decode waits while the result register is full and stalled; no new request
// is taken until that result leaves.
`default_nettype none

module light_show_command_processor #(
    parameter int TABLE_DEPTH = lscp_pkg::DEF_TABLE_DEPTH,
    parameter int PWM_TOP     = lscp_pkg::DEF_PWM_TOP
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lscp_pkg::ID_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [lscp_pkg::BYTE_W-1:0]   i_kind,
    input  wire logic [lscp_pkg::BYTE_W-1:0]   i_arg_1,
    input  wire logic [lscp_pkg::BYTE_W-1:0]   i_arg_2,
    input  wire logic [lscp_pkg::BYTE_W-1:0]   i_arg_3,
    input  wire logic [lscp_pkg::BYTE_W-1:0]   i_arg_4,
    input  wire logic [lscp_pkg::BYTE_W-1:0]   i_arg_5,
    input  wire logic [lscp_pkg::BYTE_W-1:0]   i_arg_6,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [lscp_pkg::STATUS_W-1:0]      o_status,
    output logic                               o_drive_update,
    output logic [lscp_pkg::BYTE_W-1:0]        o_red_level,
    output logic [lscp_pkg::BYTE_W-1:0]        o_green_level,
    output logic [lscp_pkg::BYTE_W-1:0]        o_blue_level
);

    lscp_pkg::t_ctrl_cmd  cmd;
    lscp_pkg::t_dp_status dp_status;
    logic                 ready;

    lscp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_ready  (ready)
    );

    lscp_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PWM_TOP     (PWM_TOP)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (dp_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_kind         (i_kind),
        .i_arg_1        (i_arg_1),
        .i_arg_2        (i_arg_2),
        .i_arg_3        (i_arg_3),
        .i_arg_4        (i_arg_4),
        .i_arg_5        (i_arg_5),
        .i_arg_6        (i_arg_6),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status_code  (o_status),
        .o_drive_update (o_drive_update),
        .o_red_level    (o_red_level),
        .o_green_level  (o_green_level),
        .o_blue_level   (o_blue_level)
    );

    assign o_stall = !ready;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking bench for the light show command processor with its own packet decoder.
module testbench;

    import lscp_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 300;   // longer than one arm sweep of the table
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 140;

    typedef struct packed {
        logic [BYTE_W-1:0] arg_6;
        logic [BYTE_W-1:0] arg_5;
        logic [BYTE_W-1:0] arg_4;
        logic [BYTE_W-1:0] arg_3;
        logic [BYTE_W-1:0] arg_2;
        logic [BYTE_W-1:0] arg_1;
        logic [BYTE_W-1:0] kind;
    } t_packet;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                drive;
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
    } t_levels;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} t_rx_mode;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [ID_W-1:0]   i_cfg_wdata = '0;
    logic              i_valid     = 1'b0;
    logic              i_stall     = 1'b0;
    t_packet           tx_pkt      = '0;

    logic                o_stall;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic                o_drive_update;
    logic [BYTE_W-1:0]   o_red_level;
    logic [BYTE_W-1:0]   o_green_level;
    logic [BYTE_W-1:0]   o_blue_level;

    // decoder model state
    logic [ID_W-1:0]   model_pack_id = '0;
    t_packet           model_last    = '0;
    logic [SHOW_W-1:0] model_show    = 16'hFFFF;
    logic [RGB_W-1:0]  model_table [DEF_TABLE_DEPTH];

    // generator view of the stream, used to build matching sequences
    t_packet           gen_last = '0;
    logic [SHOW_W-1:0] gen_show = 16'hFFFF;

    t_packet pending_requests [$];
    t_levels expected_levels [$];

    int errors       = 0;
    int n_requests   = 0;
    int n_results    = 0;
    int n_settings   = 0;
    int hold_asked   = 0;
    int status_seen [6];

    light_show_command_processor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (tx_pkt.kind),
        .i_arg_1        (tx_pkt.arg_1),
        .i_arg_2        (tx_pkt.arg_2),
        .i_arg_3        (tx_pkt.arg_3),
        .i_arg_4        (tx_pkt.arg_4),
        .i_arg_5        (tx_pkt.arg_5),
        .i_arg_6        (tx_pkt.arg_6),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_drive_update (o_drive_update),
        .o_red_level    (o_red_level),
        .o_green_level  (o_green_level),
        .o_blue_level   (o_blue_level)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [BYTE_W-1:0] compare_level(input logic [BYTE_W-1:0] colour);
        if (int'(colour) > DEF_PWM_TOP) begin
            return '0;
        end
        return BYTE_W'(DEF_PWM_TOP - int'(colour));
    endfunction

    function automatic t_levels decode_packet(input t_packet p);
        t_levels          r;
        logic [RGB_W-1:0] rgb;
        r = '0;
        r.status = ST_MISS;
        if (p == model_last) begin
            r.status = ST_DUP;
        end else begin
            model_last = p;
            case (p.kind)
                CMD_ARM: begin
                    if ({p.arg_3, p.arg_2, p.arg_1} == model_pack_id) begin
                        model_show = {p.arg_5, p.arg_4};
                        foreach (model_table[i]) model_table[i] = '0;
                        r.status = ST_ARMED;
                    end
                end
                CMD_SHOW: begin
                    rgb = '0;
                    if (int'(p.arg_1) < DEF_TABLE_DEPTH) rgb = model_table[p.arg_1];
                    r.red    = compare_level(rgb[23:16]);
                    r.green  = compare_level(rgb[15:8]);
                    r.blue   = compare_level(rgb[7:0]);
                    r.drive  = 1'b1;
                    r.status = ST_SHOWN;
                end
                CMD_SAVE: begin
                    if ({p.arg_2, p.arg_1} == model_show) r.status = ST_SAVE;
                end
                CMD_PROG: begin
                    if ({p.arg_2, p.arg_1} == model_show && int'(p.arg_3) < DEF_TABLE_DEPTH) begin
                        model_table[p.arg_3] = {p.arg_4, p.arg_5, p.arg_6};
                        r.status = ST_WROTE;
                    end
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    // Request driver: bursts of random length with random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                expected_levels.push_back(decode_packet(tx_pkt));
                n_requests++;
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                tx_pkt  <= pending_requests.pop_front();
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result stall pattern, plus a long hold-off on request.
    int       rx_tick    = 0;
    int       hold_taken = 0;
    int       hold_left  = 0;
    t_rx_mode rx_mode    = RX_OPEN;

    always @(posedge i_clk) begin
        rx_tick++;
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (rx_tick % 97 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:   i_stall <= 1'b0;
                RX_COIN:   i_stall <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_stall <= ($urandom_range(0, 7) == 0);
                default:   i_stall <= ((rx_tick % 7) < 3);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result monitor: compare against the oldest expectation.
    always @(posedge i_clk) begin
        t_levels want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (int'(o_status) < 6) status_seen[o_status]++;
            if (expected_levels.size() == 0) begin
                $display("%0t: result with no request waiting, expected none, actual status %0d",
                         $time, o_status);
                errors++;
            end else begin
                want = expected_levels.pop_front();
                check_field("status", 8'(want.status), 8'(o_status));
                check_field("drive_update", 8'(want.drive), 8'(o_drive_update));
                check_field("red_level", want.red, o_red_level);
                check_field("green_level", want.green, o_green_level);
                check_field("blue_level", want.blue, o_blue_level);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_packet(input logic [7:0] kind, input logic [7:0] a1, input logic [7:0] a2,
                                input logic [7:0] a3, input logic [7:0] a4, input logic [7:0] a5,
                                input logic [7:0] a6);
        t_packet p;
        p = {a6, a5, a4, a3, a2, a1, kind};
        pending_requests.push_back(p);
        // track what the block will hold so later requests can match it
        if (p != gen_last) begin
            gen_last = p;
            if (kind == CMD_ARM && {a3, a2, a1} == model_pack_id) gen_show = {a5, a4};
        end
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] colour_byte();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return 8'h00;
        if (roll < 4) return 8'hFF;
        return any_byte();
    endfunction

    function automatic logic [7:0] entry_byte();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return 8'($urandom_range(0, 7));
        if (roll < 6) return 8'hFF;
        return any_byte();
    endfunction

    function automatic logic [SHOW_W-1:0] show_value();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return SHOW_W'($urandom_range(0, 65535));
    endfunction

    task automatic queue_random_packet();
        int unsigned       pick;
        logic [ID_W-1:0]   id;
        logic [SHOW_W-1:0] sn;
        pick = $urandom_range(0, 99);
        id   = model_pack_id;
        sn   = gen_show;
        if (pick < 10) begin
            sn = show_value();
            queue_packet(CMD_ARM, id[7:0], id[15:8], id[23:16], sn[7:0], sn[15:8], any_byte());
        end else if (pick < 14) begin
            id = id ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
            sn = show_value();
            queue_packet(CMD_ARM, id[7:0], id[15:8], id[23:16], sn[7:0], sn[15:8], any_byte());
        end else if (pick < 44) begin
            queue_packet(CMD_PROG, sn[7:0], sn[15:8], entry_byte(), colour_byte(), colour_byte(),
                         colour_byte());
        end else if (pick < 48) begin
            sn = sn ^ (SHOW_W'(1) << $urandom_range(0, SHOW_W - 1));
            queue_packet(CMD_PROG, sn[7:0], sn[15:8], entry_byte(), colour_byte(), colour_byte(),
                         colour_byte());
        end else if (pick < 76) begin
            queue_packet(CMD_SHOW, entry_byte(), any_byte(), any_byte(), any_byte(), any_byte(),
                         any_byte());
        end else if (pick < 84) begin
            queue_packet(CMD_SAVE, sn[7:0], sn[15:8], any_byte(), any_byte(), any_byte(),
                         any_byte());
        end else if (pick < 87) begin
            sn = sn ^ (SHOW_W'(1) << $urandom_range(0, SHOW_W - 1));
            queue_packet(CMD_SAVE, sn[7:0], sn[15:8], any_byte(), any_byte(), any_byte(),
                         any_byte());
        end else if (pick < 92) begin
            queue_packet(gen_last.kind, gen_last.arg_1, gen_last.arg_2, gen_last.arg_3,
                         gen_last.arg_4, gen_last.arg_5, gen_last.arg_6);
        end else begin
            queue_packet(any_byte(), any_byte(), any_byte(), any_byte(), any_byte(), any_byte(),
                         any_byte());
        end
    endtask

    // Wait until every request is in and answered, then let a sweep finish.
    task automatic drain_and_settle();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || i_valid || expected_levels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_pack_id(input logic [ID_W-1:0] id);
        @(posedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_wdata   <= id;
        model_pack_id = id;
        n_settings++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [ID_W-1:0] phase_ids [6];
        foreach (model_table[i]) model_table[i] = '0;
        phase_ids[0] = '0;
        phase_ids[1] = '1;
        phase_ids[2] = ID_W'($urandom);
        phase_ids[3] = 24'h800001;
        phase_ids[4] = ID_W'($urandom);
        phase_ids[5] = ID_W'($urandom);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pack id at its reset value
        queue_packet(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);   // equals reset history
        queue_packet(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_packet(CMD_SAVE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_packet(CMD_PROG, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF);
        queue_packet(CMD_SHOW, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_packet(CMD_SHOW, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_packet(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);   // unknown command
        queue_packet(CMD_ARM, 8'h00, 8'h00, 8'h00, 8'h34, 8'h12, 8'h00);
        queue_packet(CMD_SHOW, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_packet(CMD_PROG, 8'hFF, 8'hFF, 8'h00, 8'h11, 8'h22, 8'h33);
        queue_packet(CMD_SAVE, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00);
        queue_packet(CMD_PROG, 8'h34, 8'h12, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        queue_packet(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_packet(CMD_ARM, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_packet(CMD_SAVE, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00);
        drain_and_settle();

        write_pack_id('1);
        queue_packet(CMD_ARM, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        queue_packet(CMD_PROG, 8'h00, 8'h00, 8'h07, 8'h12, 8'h34, 8'h56);
        queue_packet(CMD_SHOW, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_packet(CMD_ARM, 8'h00, 8'h00, 8'h00, 8'h34, 8'h12, 8'h00);
        queue_packet(CMD_SAVE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        drain_and_settle();

        foreach (phase_ids[ph]) begin
            write_pack_id(phase_ids[ph]);
            repeat (PHASE_ITEMS) queue_random_packet();
            // hold off results while requests keep coming so the block backs up
            if (ph == 1 || ph == 4) hold_asked++;
            drain_and_settle();
        end

        if (expected_levels.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_levels.size());
            errors++;
        end
        $display("ran %0d requests and %0d results across %0d pack id settings",
                 n_requests, n_results, n_settings + 1);
        $display("status counts dup/miss/armed/shown/wrote/save: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
